// ----- design/stxl_pkg.sv -----
// Shared types, constants and register codes for the scored vector table.
package stxl_pkg;

  localparam int DEF_TABLE_DEPTH   = 64;
  localparam int DEF_MAX_LOCATIONS = 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_LOCATIONS_IN_USE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_IN_USE   = 1'b1;

  localparam logic [3:0] LOCATIONS_RESET = 4'd8;
  localparam logic [6:0] ENTRIES_RESET   = 7'd64;

  // Score of an empty entry: -1.0 in Q16.16.
  localparam logic signed [31:0] EMPTY_SCORE = 32'shFFFF_0000;

  typedef enum logic [2:0] {
    STATUS_MISS     = 3'd0,
    STATUS_HIT      = 3'd1,
    STATUS_INSERTED = 3'd2,
    STATUS_REPLACED = 3'd3,
    STATUS_REJECTED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REPLACE,
    ST_READ_LOC,
    ST_EMIT_LOC,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        location;
    logic signed [31:0] score;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         slot;
    logic signed [31:0] entry_score;
    logic [15:0]        entry_location;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic    accept;
    logic    scan_start;
    logic    scan_run;
    logic    take_free_slot;
    logic    take_worst_slot;
    logic    j_clear;
    logic    j_inc;
    logic    qbuf_rd;
    logic    loc_wr;
    logic    loc_rd;
    logic    commit;
    logic    out_load;
    logic    status_we;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic final_item;
    logic mode;
    logic free;
    logic scan_hit;
    logic scan_empty;
    logic scan_end;
    logic better;
    logic j_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/stxl_dp.sv -----
// Datapath of the scored vector table: buffers, table memories, scan unit and output register.
module stxl_dp
  import stxl_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_LOCATIONS = DEF_MAX_LOCATIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  in_word_t               in_word,
  input  logic                   out_stall,
  output logic                   out_valid,
  output out_word_t              out_word,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  dp_cmd_t                cmd,
  output dp_status_t             sts
);

  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int FILL_W    = $clog2(TABLE_DEPTH + 1);
  localparam int LIDX_W    = (MAX_LOCATIONS > 1) ? $clog2(MAX_LOCATIONS) : 1;
  localparam int LCNT_W    = $clog2(MAX_LOCATIONS + 1);
  localparam int LOC_DEPTH = TABLE_DEPTH * MAX_LOCATIONS;
  localparam int LA_W      = $clog2(LOC_DEPTH);
  localparam int TC_W      = (FILL_W > 7) ? FILL_W : 7;
  localparam int NC_W      = (LCNT_W > 4) ? LCNT_W : 4;

  logic [3:0]         locations_in_use;
  logic [6:0]         entries_in_use;
  logic [LCNT_W-1:0]  n_len;
  logic [FILL_W-1:0]  t_len;

  logic [LCNT_W-1:0]  elem_count;
  logic [LCNT_W-1:0]  count_inc;
  logic [15:0]        query_sig;
  logic [15:0]        sig_next;
  logic [15:0]        qbuf [MAX_LOCATIONS];
  logic [15:0]        qbuf_q;

  logic               op_mode;
  logic [15:0]        op_sig;
  logic signed [31:0] op_score;

  logic signed [31:0] score_mem [TABLE_DEPTH];
  logic [15:0]        sig_mem [TABLE_DEPTH];
  logic [15:0]        loc_mem [LOC_DEPTH];
  logic [15:0]        loc_q;

  logic [FILL_W-1:0]  fill_count;
  logic [FILL_W-1:0]  limit;
  logic [FILL_W-1:0]  issue_addr;
  logic               issue_more;
  logic               rd_valid;
  logic [IDX_W-1:0]   rd_idx;
  logic signed [31:0] rd_score;
  logic [15:0]        rd_sig;

  logic [IDX_W-1:0]   hit_idx;
  logic signed [31:0] hit_score;
  logic [IDX_W-1:0]   worst_idx;
  logic signed [31:0] worst;
  logic [IDX_W-1:0]   wr_slot;
  status_t            res_status;
  logic [LIDX_W-1:0]  j;
  logic [LA_W-1:0]    loc_wr_addr;
  logic [LA_W-1:0]    loc_rd_addr;
  out_word_t          out_word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      locations_in_use <= LOCATIONS_RESET;
      entries_in_use   <= ENTRIES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOCATIONS_IN_USE: locations_in_use <= cfg_data[3:0];
        REG_ENTRIES_IN_USE:   entries_in_use   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (locations_in_use == 4'd0) begin
      n_len = LCNT_W'(1);
    end else if (NC_W'(locations_in_use) > NC_W'(MAX_LOCATIONS)) begin
      n_len = LCNT_W'(MAX_LOCATIONS);
    end else begin
      n_len = LCNT_W'(locations_in_use);
    end
  end

  always_comb begin
    if (entries_in_use == 7'd0) begin
      t_len = FILL_W'(1);
    end else if (TC_W'(entries_in_use) > TC_W'(TABLE_DEPTH)) begin
      t_len = FILL_W'(TABLE_DEPTH);
    end else begin
      t_len = FILL_W'(entries_in_use);
    end
  end

  assign count_inc       = elem_count + LCNT_W'(1);
  assign sig_next        = query_sig ^ in_word.location;
  assign sts.final_item  = (count_inc >= n_len);
  assign sts.mode        = in_word.mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      query_sig  <= '0;
    end else if (cmd.accept) begin
      if (sts.final_item) begin
        elem_count <= '0;
        query_sig  <= '0;
      end else begin
        elem_count <= count_inc;
        query_sig  <= sig_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      qbuf[elem_count[LIDX_W-1:0]] <= in_word.location;
    end
    if (cmd.qbuf_rd) begin
      qbuf_q <= qbuf[j];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.final_item) begin
      op_mode  <= in_word.mode;
      op_sig   <= sig_next;
      op_score <= in_word.score;
    end
  end

  assign limit      = op_mode ? t_len : ((fill_count < t_len) ? fill_count : t_len);
  assign issue_more = (issue_addr < limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_addr <= '0;
      rd_valid   <= 1'b0;
    end else if (cmd.scan_start) begin
      issue_addr <= '0;
      rd_valid   <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_valid <= issue_more;
      if (issue_more) begin
        issue_addr <= issue_addr + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run && issue_more) begin
      rd_score <= score_mem[issue_addr[IDX_W-1:0]];
      rd_sig   <= sig_mem[issue_addr[IDX_W-1:0]];
      rd_idx   <= issue_addr[IDX_W-1:0];
    end
    if (cmd.commit) begin
      score_mem[wr_slot] <= op_score;
      sig_mem[wr_slot]   <= op_sig;
    end
  end

  assign sts.scan_hit   = rd_valid && (rd_score != EMPTY_SCORE) && (rd_sig == op_sig);
  assign sts.scan_empty = rd_valid && (rd_score == EMPTY_SCORE);
  assign sts.scan_end   = !rd_valid && !issue_more;
  assign sts.better     = (op_score > worst);
  assign sts.free       = (fill_count < t_len);

  always_ff @(posedge clk) begin
    if (cmd.scan_run && sts.scan_hit) begin
      hit_idx   <= rd_idx;
      hit_score <= rd_score;
    end
    if (cmd.scan_run && rd_valid) begin
      if ((rd_idx == '0) || (rd_score < worst)) begin
        worst     <= rd_score;
        worst_idx <= rd_idx;
      end
    end
    if (cmd.take_free_slot) begin
      wr_slot <= fill_count[IDX_W-1:0];
    end else if (cmd.take_worst_slot) begin
      wr_slot <= worst_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      res_status <= STATUS_MISS;
    end else begin
      if (cmd.commit && (res_status == STATUS_INSERTED)) begin
        fill_count <= fill_count + FILL_W'(1);
      end
      if (cmd.status_we) begin
        res_status <= cmd.status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.j_clear) begin
      j <= '0;
    end else if (cmd.j_inc) begin
      j <= j + LIDX_W'(1);
    end
  end

  assign sts.j_last = ((LCNT_W'(j) + LCNT_W'(1)) == n_len);

  assign loc_wr_addr = LA_W'(wr_slot) * LA_W'(MAX_LOCATIONS) + LA_W'(j);
  assign loc_rd_addr = LA_W'(hit_idx) * LA_W'(MAX_LOCATIONS) + LA_W'(j);

  always_ff @(posedge clk) begin
    if (cmd.loc_wr) begin
      loc_mem[loc_wr_addr] <= qbuf_q;
    end
    if (cmd.loc_rd) begin
      loc_q <= loc_mem[loc_rd_addr];
    end
  end

  always_comb begin
    out_word_next        = '0;
    out_word_next.status = res_status;
    out_word_next.last   = 1'b1;
    case (res_status) inside
      STATUS_HIT: begin
        out_word_next.slot           = 6'(hit_idx);
        out_word_next.entry_score    = hit_score;
        out_word_next.entry_location = loc_q;
        out_word_next.last           = sts.j_last;
      end
      STATUS_INSERTED, STATUS_REPLACED: begin
        out_word_next.slot = 6'(wr_slot);
      end
      default: begin
      end
    endcase
  end

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word <= out_word_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result word loaded over a word not yet taken");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (res_status == STATUS_INSERTED)) |=>
      (fill_count == $past(fill_count) + FILL_W'(1)))
    else $error("fill count did not advance after a free-slot insert");

  a_commit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (FILL_W'(wr_slot) < t_len))
    else $error("entry written outside the table in use");

  a_hit_filled: assert property (@(posedge clk) disable iff (rst)
    cmd.loc_rd |-> (FILL_W'(hit_idx) < fill_count))
    else $error("hit on an entry that was never filled");

endmodule

// ----- design/stxl_ctrl.sv -----
// Controller state machine that sequences accept, scan, copy and result output.
module stxl_ctrl
  import stxl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && sts.final_item) begin
          if (!sts.mode) begin
            state_next = ST_SEARCH;
          end else if (sts.free) begin
            state_next = ST_COPY_RD;
          end else begin
            state_next = ST_REPLACE;
          end
        end
      end
      ST_SEARCH: begin
        if (sts.scan_hit) begin
          state_next = ST_READ_LOC;
        end else if (sts.scan_empty || sts.scan_end) begin
          state_next = ST_EMIT;
        end
      end
      ST_REPLACE: begin
        if (sts.scan_end) begin
          state_next = sts.better ? ST_COPY_RD : ST_EMIT;
        end
      end
      ST_READ_LOC: state_next = ST_EMIT_LOC;
      ST_EMIT_LOC: begin
        if (sts.out_free) begin
          state_next = sts.j_last ? ST_IDLE : ST_READ_LOC;
        end
      end
      ST_COPY_RD:  state_next = ST_COPY_WR;
      ST_COPY_WR:  state_next = sts.j_last ? ST_COMMIT : ST_COPY_RD;
      ST_COMMIT:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && sts.final_item) begin
          if (sts.mode && sts.free) begin
            cmd.take_free_slot = 1'b1;
            cmd.j_clear        = 1'b1;
            cmd.status_we      = 1'b1;
            cmd.status         = STATUS_INSERTED;
          end else begin
            cmd.scan_start = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_hit) begin
          cmd.status_we = 1'b1;
          cmd.status    = STATUS_HIT;
          cmd.j_clear   = 1'b1;
        end else if (sts.scan_empty || sts.scan_end) begin
          cmd.status_we = 1'b1;
          cmd.status    = STATUS_MISS;
        end
      end
      ST_REPLACE: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_end) begin
          cmd.status_we = 1'b1;
          if (sts.better) begin
            cmd.take_worst_slot = 1'b1;
            cmd.j_clear         = 1'b1;
            cmd.status          = STATUS_REPLACED;
          end else begin
            cmd.status = STATUS_REJECTED;
          end
        end
      end
      ST_READ_LOC: cmd.loc_rd = 1'b1;
      ST_EMIT_LOC: begin
        cmd.out_load = sts.out_free;
        cmd.j_inc    = sts.out_free;
      end
      ST_COPY_RD:  cmd.qbuf_rd = 1'b1;
      ST_COPY_WR: begin
        cmd.loc_wr = 1'b1;
        cmd.j_inc  = 1'b1;
      end
      ST_COMMIT:   cmd.commit = 1'b1;
      ST_EMIT:     cmd.out_load = sts.out_free;
    endcase
  end

endmodule

// ----- design/scored_table_xor_lookup_replace_worst_top.sv -----
// Top level of the scored vector table with signature lookup and replace-worst insert.
//
// Input words carry one location each; a vector ends when its element count
// reaches locations_in_use, and the mode of that final word selects search or
// insert. A non-final word is taken while the block is idle and gives no result.
// A search scans the filled entries at one entry a cycle through the score and
// signature memories, then gives one miss word or a run of locations_in_use
// hit words, each read through the registered location memory port before it
// is loaded into the output register. An insert into a free slot copies the
// vector one location at a time, reading the query buffer and then writing the
// location memory, and gives one word; with the table full it first scans
// entries_in_use entries for the lowest score. One item is handled at a time.
// Reset clears the fill count, so the whole table reads as empty at once;
// registers return to eight locations and sixty-four entries.
// The result word sits in an output register, so a final word may be taken while the
// previous result is still stalled; the block waits in its output state while stall
// is high and the payload holds. Configuration writes take effect at once; the user
// makes them only while no operation is in flight; the block does not enforce it.
module scored_table_xor_lookup_replace_worst_top
  import stxl_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_LOCATIONS = DEF_MAX_LOCATIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_word_t               in_word,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_word_t              out_word,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  stxl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  stxl_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_LOCATIONS (MAX_LOCATIONS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
